[rtl/cid_pkg.sv]
// ----------------------------------------------------------------------------
// cid_pkg: shared types and constants of the compact integer decoder
// Holds the code-state and result structs, format selectors and prefix codes.
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 3;
  localparam int unsigned SeenW  = 3;

  // Format selector held in the mode register
  localparam logic MODE_COMPACT = 1'b0;
  localparam logic MODE_GROUP   = 1'b1;

  // Compact format prefix bytes
  localparam logic [ByteW-1:0] PREFIX_SHORT = 8'h80;
  localparam logic [ByteW-1:0] PREFIX_WIDE  = 8'h81;

  // Bits 28..31 set by a negative four-byte group code
  localparam logic [ValueW-1:0] GROUP_SIGN_MASK = 32'hF000_0000;

  // Code lengths in bytes
  localparam logic [LenW-1:0] LEN_ONE   = 3'd1;
  localparam logic [LenW-1:0] LEN_TWO   = 3'd2;
  localparam logic [LenW-1:0] LEN_THREE = 3'd3;
  localparam logic [LenW-1:0] LEN_FOUR  = 3'd4;
  localparam logic [LenW-1:0] LEN_FIVE  = 3'd5;

  // Code in progress
  typedef struct packed {
    logic [SeenW-1:0]  bytes_seen;
    logic [ValueW-1:0] partial_value;
    logic              wide_prefix;
  } cid_state_t;

  // One decoded value
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] decoded_value;
    logic [LenW-1:0]   code_length;
  } cid_result_t;

endpackage

[rtl/cid_decode.sv]
// ----------------------------------------------------------------------------
// cid_decode: single-byte decode step
// Combines one byte with the code in progress; gives the next code state and
// a result when the byte completes a code.
// ----------------------------------------------------------------------------
module cid_decode
  import cid_pkg::*;
(
  input  logic                 mode_i,
  input  logic [ByteW-1:0]     byte_i,
  input  cid_state_t           state_i,
  output cid_state_t           state_o,
  output cid_result_t          result_o
);

  logic [1:0]        lane;
  logic [ValueW-1:0] lane_word;
  logic [ValueW-1:0] gathered;
  logic [ValueW-1:0] grp;

  assign lane      = state_i.bytes_seen[1:0] - 2'd1;
  assign lane_word = {{(ValueW-ByteW){1'b0}}, byte_i} << {lane, 3'b000};
  assign gathered  = state_i.partial_value | lane_word;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    grp      = '0;
    if (mode_i == MODE_COMPACT) begin
      if (state_i.bytes_seen == '0) begin
        if (byte_i == PREFIX_SHORT || byte_i == PREFIX_WIDE) begin
          state_o.wide_prefix   = byte_i[0];
          state_o.partial_value = '0;
          state_o.bytes_seen    = 3'd1;
        end else begin
          result_o.valid         = 1'b1;
          result_o.decoded_value = {{(ValueW-ByteW){byte_i[ByteW-1]}}, byte_i};
          result_o.code_length   = LEN_ONE;
        end
      end else begin
        state_o.partial_value = gathered;
        state_o.bytes_seen    = state_i.bytes_seen + 3'd1;
        if (!state_i.wide_prefix && lane == 2'd1) begin
          result_o.valid         = 1'b1;
          result_o.decoded_value = {{16{gathered[15]}}, gathered[15:0]};
          result_o.code_length   = LEN_THREE;
        end else if (state_i.wide_prefix && lane == 2'd3) begin
          result_o.valid         = 1'b1;
          result_o.decoded_value = gathered;
          result_o.code_length   = LEN_FIVE;
        end
        if (result_o.valid) begin
          state_o = '0;
        end
      end
    end else begin
      unique case (state_i.bytes_seen)
        3'd0: begin
          if (!byte_i[7]) begin
            result_o.valid         = 1'b1;
            result_o.decoded_value = {{(ValueW-ByteW){1'b0}}, byte_i};
            result_o.code_length   = LEN_ONE;
          end else begin
            state_o.partial_value = {25'b0, byte_i[6:0]};
            state_o.bytes_seen    = 3'd1;
          end
        end
        3'd1: begin
          grp = state_i.partial_value | ({24'b0, byte_i} << 7);
          if (!grp[14]) begin
            result_o.valid         = 1'b1;
            result_o.decoded_value = grp;
            result_o.code_length   = LEN_TWO;
          end else begin
            grp[14]               = 1'b0;
            state_o.partial_value = grp;
            state_o.bytes_seen    = 3'd2;
          end
        end
        3'd2: begin
          grp = state_i.partial_value | ({24'b0, byte_i} << 14);
          if (!grp[21]) begin
            result_o.valid         = 1'b1;
            result_o.decoded_value = grp;
            result_o.code_length   = LEN_THREE;
          end else begin
            grp[21]               = 1'b0;
            state_o.partial_value = grp;
            state_o.bytes_seen    = 3'd3;
          end
        end
        default: begin
          // fourth byte is taken whole; bit 28 sign-extends
          grp = state_i.partial_value | ({24'b0, byte_i} << 21);
          if (grp[28]) begin
            grp = grp | GROUP_SIGN_MASK;
          end
          result_o.valid         = 1'b1;
          result_o.decoded_value = grp;
          result_o.code_length   = LEN_FOUR;
        end
      endcase
      if (result_o.valid) begin
        state_o = '0;
      end
    end
  end

endmodule

[rtl/compact_int_decoder_top.sv]
// ----------------------------------------------------------------------------
// compact_int_decoder_top: variable-length 32-bit integer decoder
// Decodes a byte stream in signed prefix compact format or 7-bit group format
// and emits one word per completed code with its byte length.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+--------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | in_byte [7:0]
//  m_axis  | out | m_axis_tvalid / m_axis_tready | decoded_value [31:0],
//          |     |                              | code_length [34:32], zero [39:35]
//  cfg     | in  | cfg_we_i                     | format_mode = cfg_wdata_i
//
//  One byte is taken every cycle unless a stall on m_axis backs up into the
//  input register. A byte passes an input register and the result register,
//  and a completed code shows on m_axis from the result register; the
//  combinational decode step sits between the two registers.
//  A stall on m_axis holds the result register and backs up into the input
//  register only once both are full; ready on s_axis does not wait for idle.
//  Reset clears the code in progress, both valid flags and selects compact
//  format. A write to the mode register drops any code in progress.
//
module compact_int_decoder_top
  import cid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // format_mode
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
  // decoded values out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata     // [31:0] decoded_value, [34:32] code_length
);

  logic              mode_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  cid_state_t        state_q, state_d;
  cid_result_t       result_d;
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic [LenW-1:0]   out_len_q;
  logic              advance;

  // Advance the held byte when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  cid_decode u_decode (
    .mode_i   (mode_q),
    .byte_i   (in_byte_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Mode register and code in progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_COMPACT;
      state_q <= '0;
    end else if (cfg_we_i) begin
      mode_q  <= cfg_wdata_i;
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Result register: load on a completed code, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result_d.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result_d.valid) begin
      out_value_q <= result_d.decoded_value;
      out_len_q   <= result_d.code_length;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_len_q, out_value_q};

endmodule
